@@ sv/aes_pkg.sv @@
package aes_pkg;

   localparam int RoundCountDefault = 10;

   localparam logic [0:0] CMD_ENCRYPT = 1'b0;
   localparam logic [0:0] CMD_DECRYPT = 1'b1;

   localparam logic [0:0] CSR_KEY_HIGH = 1'b0;
   localparam logic [0:0] CSR_KEY_LOW  = 1'b1;

   typedef struct packed {
      logic         load;
      logic         decrypt;
      logic         first;
      logic         run;
      logic         last;
      logic         key_start;
      logic         key_step;
   } aes_cmd_type;

   function automatic logic [7:0] xtime(input logic [7:0] b);
      xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'h00;
      x = a;
      for (int i = 0; i < 4; i++) begin
         if (b[i]) acc = acc ^ x;
         x = xtime(x);
      end
      gf_mul = acc;
   endfunction

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      sbox = t[x];
   endfunction

   function automatic logic [7:0] inv_sub_byte(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
         8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
         8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
         8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
         8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
         8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
         8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
         8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
         8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
         8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
         8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
         8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
         8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
         8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
         8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
         8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
         8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      inv_sub_byte = t[x];
   endfunction

endpackage

@@ sv/aes128_block_cipher.sv @@
// AES-128 ECB encrypt/decrypt engine. Write the key through the csr port
// (index 0 key bytes 0..7, index 1 key bytes 8..15); after reset or a key write
// the round key schedule is rebuilt, and no request is taken while it is rebuilt.
// After a request is accepted, the initial key addition is done, then ten rounds
// run through one shared round unit, one per cycle, with the next round key read
// from the key store in the cycle before. The engine returns to idle at the edge
// that takes the response, so a new block is accepted only after the response to
// the last one is taken.
// cmd 0 encrypts, 1 decrypts.
module aes128_block_cipher
   import aes_pkg::*;
#(
   parameter int ROUND_COUNT = RoundCountDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [63:0] req_block_in_high,
   input  logic [63:0] req_block_in_low,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_block_out_high,
   output logic [63:0] rsp_block_out_low,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [63:0] key_high_ff, key_low_ff;
   logic        key_write;
   aes_cmd_type cmd;
   logic [$clog2(ROUND_COUNT+1)-1:0] round_idx;
   logic [127:0] block_out;

   assign key_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (key_write) begin
         case (csr_index)
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   aes_ctrl #(.ROUND_COUNT(ROUND_COUNT)) u_ctrl (
      .clock, .reset, .req_valid, .req_cmd, .req_ready, .rsp_valid, .rsp_ready,
      .key_write, .csr_ready, .cmd, .round_idx
   );

   aes_datapath #(.ROUND_COUNT(ROUND_COUNT)) u_dp (
      .clock, .cmd, .round_idx,
      .block_in({req_block_in_high, req_block_in_low}),
      .key_in({key_high_ff, key_low_ff}),
      .block_out
   );

   assign rsp_block_out_high = block_out[127:64];
   assign rsp_block_out_low  = block_out[63:0];

endmodule

@@ sv/aes_datapath.sv @@
module aes_datapath
   import aes_pkg::*;
#(
   parameter int ROUND_COUNT = RoundCountDefault
) (
   input  logic                          clock,
   input  aes_cmd_type                   cmd,
   input  logic [$clog2(ROUND_COUNT+1)-1:0] round_idx,
   input  logic [127:0]                  block_in,
   input  logic [127:0]                  key_in,
   output logic [127:0]                  block_out
);

   localparam int RW = $clog2(ROUND_COUNT + 1);
   localparam int KW = $clog2(4 * (ROUND_COUNT + 1));

   logic [127:0] state_ff, state_in;
   logic [127:0] kacc_ff, kacc_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [KW-3:0] kwr_ff, kwr_in;
   logic [127:0] rk_mem [ROUND_COUNT+1];
   logic [127:0] rk_rd_ff;

   // key expansion, one round key per cycle
   logic [31:0] rot, sub;
   logic [127:0] knext;
   always_comb begin
      rot = {kacc_ff[23:0], kacc_ff[31:24]};
      for (int i = 0; i < 4; i++) sub[8*i +: 8] = sbox(rot[8*i +: 8]);
      knext[127:96] = kacc_ff[127:96] ^ sub ^ {rcon_ff, 24'h0};
      knext[95:64]  = kacc_ff[95:64] ^ knext[127:96];
      knext[63:32]  = kacc_ff[63:32] ^ knext[95:64];
      knext[31:0]   = kacc_ff[31:0] ^ knext[63:32];
   end

   always_comb begin
      kacc_in = kacc_ff;
      rcon_in = rcon_ff;
      kwr_in  = kwr_ff;
      if (cmd.key_start) begin
         kacc_in = key_in;
         rcon_in = 8'h01;
         kwr_in  = '0;
      end else if (cmd.key_step) begin
         kacc_in = knext;
         rcon_in = xtime(rcon_ff);
         kwr_in  = kwr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      kacc_ff <= kacc_in;
      rcon_ff <= rcon_in;
      kwr_ff  <= kwr_in;
      if (cmd.key_step) rk_mem[kwr_ff[RW-1:0]] <= kacc_ff;
      rk_rd_ff <= rk_mem[round_idx];
   end

   // byte n is at bits 127-8n
   function automatic logic [7:0] gb(input logic [127:0] s, input int n);
      gb = s[127-8*n -: 8];
   endfunction

   logic [127:0] sh, sb, mx, ark, enc_r, dec_r;
   always_comb begin
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++) begin
            sh[127-8*(r+4*c) -: 8] = sbox(gb(state_ff, r + 4*((c+r)&3)));
         end
      enc_r = sh;
      if (!cmd.last) begin
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
               mx[127-8*(r+4*c) -: 8] =
                  xtime(gb(sh, r+4*c)) ^ xtime(gb(sh, ((r+1)&3)+4*c))
                  ^ gb(sh, ((r+1)&3)+4*c) ^ gb(sh, ((r+2)&3)+4*c)
                  ^ gb(sh, ((r+3)&3)+4*c);
            end
         enc_r = mx;
      end else begin
         mx = '0;
      end
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            sb[127-8*(r+4*((c+r)&3)) -: 8] = inv_sub_byte(gb(state_ff, r+4*c));
      ark = sb ^ rk_rd_ff;
      dec_r = ark;
      if (!cmd.last) begin
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               dec_r[127-8*(r+4*c) -: 8] =
                  gf_mul(gb(ark, r+4*c), 8'd14) ^ gf_mul(gb(ark, ((r+1)&3)+4*c), 8'd11)
                  ^ gf_mul(gb(ark, ((r+2)&3)+4*c), 8'd13)
                  ^ gf_mul(gb(ark, ((r+3)&3)+4*c), 8'd9);
      end
      if (cmd.load) state_in = block_in;
      else if (cmd.first) state_in = state_ff ^ rk_rd_ff;
      else if (cmd.run && cmd.decrypt) state_in = dec_r;
      else if (cmd.run) state_in = enc_r ^ rk_rd_ff;
      else state_in = state_ff;
   end

   always_ff @(posedge clock) state_ff <= state_in;

   assign block_out = state_ff;

endmodule

@@ sv/aes_ctrl.sv @@
module aes_ctrl
   import aes_pkg::*;
#(
   parameter int ROUND_COUNT = RoundCountDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_cmd,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          key_write,
   output logic                          csr_ready,
   output aes_cmd_type                   cmd,
   output logic [$clog2(ROUND_COUNT+1)-1:0] round_idx
);

   localparam int RW = $clog2(ROUND_COUNT + 1);
   localparam logic [RW-1:0] LastRound = RW'(ROUND_COUNT);

   localparam logic [2:0] ST_KEY   = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_FIRST = 3'd3;
   localparam logic [2:0] ST_ROUND = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [RW-1:0] cnt_ff, cnt_in;
   logic          dec_ff, dec_in;
   logic          kpend_ff, kpend_in;

   assign req_ready = (state_ff == ST_IDLE) && !kpend_ff;
   assign rsp_valid = (state_ff == ST_DONE);
   assign csr_ready = (state_ff == ST_IDLE) || (state_ff == ST_KEY);

   // round key for the next count: encrypt counts up, decrypt counts down
   assign round_idx = dec_in ? (LastRound - cnt_in) : cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dec_in   = dec_ff;
      kpend_in = kpend_ff || key_write;
      cmd      = '0;
      cmd.decrypt = dec_ff;
      cmd.last    = (cnt_ff == LastRound);
      case (state_ff)
         ST_KEY: begin
            cmd.key_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LastRound) begin
               state_in = ST_IDLE;
               cnt_in = '0;
            end
         end
         ST_IDLE: begin
            if (kpend_ff) begin
               cmd.key_start = 1'b1;
               kpend_in = key_write;
               cnt_in = '0;
               state_in = ST_KEY;
            end else if (req_valid) begin
               cmd.load = 1'b1;
               dec_in = req_cmd;
               cnt_in = '0;
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            cmd.first = 1'b1;
            state_in = ST_ROUND;
            cnt_in = cnt_ff + 1'b1;
         end
         ST_ROUND: begin
            cmd.run = 1'b1;
            if (cnt_ff == LastRound) state_in = ST_DONE;
            else cnt_in = cnt_ff + 1'b1;
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
               cnt_in = '0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         dec_ff   <= 1'b0;
         kpend_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         dec_ff   <= dec_in;
         kpend_ff <= kpend_in;
      end
   end

endmodule

@@ sv/aes_checker.sv @@
module aes_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_block_out_high
);

   // no new request while a response is pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready during response");

   // response follows a request by a fixed latency
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##12 rsp_valid) else $error("latency");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block_out_high))
      else $error("response dropped");

endmodule

bind aes128_block_cipher aes_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_block_out_high
);
